@@ rtl/cfba_pkg.sv @@
// shared types, codes and control store of the chained free-block allocator
package cfba_pkg;

    // transaction codes on the input side
    localparam logic [1:0] CMD_ALLOC     = 2'd0;
    localparam logic [1:0] CMD_RELEASE   = 2'd1;
    localparam logic [1:0] CMD_FILL_CNT  = 2'd2;
    localparam logic [1:0] CMD_FILL_ENT  = 2'd3;

    // result kinds on the output side
    localparam logic [2:0] KIND_ALLOC     = 3'd0;
    localparam logic [2:0] KIND_NOSPACE   = 3'd1;
    localparam logic [2:0] KIND_BAD       = 3'd2;
    localparam logic [2:0] KIND_FETCH     = 3'd3;
    localparam logic [2:0] KIND_SPILL_CNT = 3'd4;
    localparam logic [2:0] KIND_SPILL_ENT = 3'd5;
    localparam logic [2:0] KIND_RELEASED  = 3'd6;
    localparam logic [2:0] KIND_BUSY      = 3'd7;

    // configuration register indexes
    localparam logic REG_DATA_START    = 1'b0;
    localparam logic REG_VOLUME_BLOCKS = 1'b1;

    typedef logic [4:0] step_t;

    // control store addresses
    localparam step_t S_IDLE      = 5'd0;
    localparam step_t S_BUSY      = 5'd1;
    localparam step_t S_A_CLAMP   = 5'd2;
    localparam step_t S_A_TEST    = 5'd3;
    localparam step_t S_A_POP     = 5'd4;
    localparam step_t S_A_ZERO    = 5'd5;
    localparam step_t S_A_RANGE   = 5'd6;
    localparam step_t S_A_LAST    = 5'd7;
    localparam step_t S_A_GRANT   = 5'd8;
    localparam step_t S_A_BAD     = 5'd9;
    localparam step_t S_A_NOSP    = 5'd10;
    localparam step_t S_A_FETCH   = 5'd11;
    localparam step_t S_R_CLAMP   = 5'd12;
    localparam step_t S_R_RANGE   = 5'd13;
    localparam step_t S_R_EMPTY   = 5'd14;
    localparam step_t S_R_SEED    = 5'd15;
    localparam step_t S_R_FULL    = 5'd16;
    localparam step_t S_R_SPCNT   = 5'd17;
    localparam step_t S_R_SPENT   = 5'd18;
    localparam step_t S_R_RESTART = 5'd19;
    localparam step_t S_R_PUSH    = 5'd20;
    localparam step_t S_R_BAD     = 5'd21;
    localparam step_t S_F_CNT     = 5'd22;
    localparam step_t S_F_LOAD    = 5'd23;
    localparam step_t S_F_FAIL    = 5'd24;
    localparam step_t S_F_ENT     = 5'd25;
    localparam step_t S_F_DONE    = 5'd26;
    localparam step_t S_F_GRANT   = 5'd27;

    // branch conditions
    typedef enum logic [3:0] {
        C_NEVER,
        C_ALWAYS,
        C_CNT_ZERO,
        C_CNT_NZ,
        C_CNT_LT_DEPTH,
        C_RD_ZERO,
        C_RD_BAD,
        C_BN_BAD,
        C_RF,
        C_FILL_NOT_LAST,
        C_LOADED_ZERO,
        C_SPILL_MORE
    } cond_t;

    // datapath operations
    typedef enum logic [3:0] {
        ACT_NONE,
        ACT_WAIT_IN,
        ACT_CLAMP,
        ACT_POP,
        ACT_CNT_CLEAR,
        ACT_FETCH_SET,
        ACT_SEED,
        ACT_SPILL_INIT,
        ACT_SPILL_NEXT,
        ACT_PUSH,
        ACT_LOAD_CNT,
        ACT_FAIL,
        ACT_FILL,
        ACT_FILL_DONE
    } act_t;

    typedef enum logic [1:0] {
        BLK_ZERO,
        BLK_RD,
        BLK_BN,
        BLK_PEND
    } blk_sel_t;

    typedef enum logic [1:0] {
        WORD_ZERO,
        WORD_COUNT,
        WORD_RD
    } word_sel_t;

    // one control word
    typedef struct packed {
        cond_t      cond;
        step_t      target;
        act_t       act;
        logic       emit;
        logic [2:0] kind;
        blk_sel_t   blk_sel;
        word_sel_t  word_sel;
        logic       last;
    } uword_t;

    // control store
    function automatic uword_t ucode_rom(input step_t step);
        uword_t w;
        unique case (step)
            S_IDLE:      w = '{C_NEVER, S_IDLE, ACT_WAIT_IN, 1'b0, KIND_ALLOC,
                               BLK_ZERO, WORD_ZERO, 1'b0};
            S_BUSY:      w = '{C_ALWAYS, S_IDLE, ACT_NONE, 1'b1, KIND_BUSY,
                               BLK_ZERO, WORD_ZERO, 1'b1};
            S_A_CLAMP:   w = '{C_NEVER, S_IDLE, ACT_CLAMP, 1'b0, KIND_ALLOC,
                               BLK_ZERO, WORD_ZERO, 1'b0};
            S_A_TEST:    w = '{C_CNT_ZERO, S_A_NOSP, ACT_NONE, 1'b0, KIND_ALLOC,
                               BLK_ZERO, WORD_ZERO, 1'b0};
            S_A_POP:     w = '{C_NEVER, S_IDLE, ACT_POP, 1'b0, KIND_ALLOC,
                               BLK_ZERO, WORD_ZERO, 1'b0};
            S_A_ZERO:    w = '{C_RD_ZERO, S_A_NOSP, ACT_NONE, 1'b0, KIND_ALLOC,
                               BLK_ZERO, WORD_ZERO, 1'b0};
            S_A_RANGE:   w = '{C_RD_BAD, S_A_BAD, ACT_NONE, 1'b0, KIND_ALLOC,
                               BLK_ZERO, WORD_ZERO, 1'b0};
            S_A_LAST:    w = '{C_CNT_ZERO, S_A_FETCH, ACT_NONE, 1'b0, KIND_ALLOC,
                               BLK_ZERO, WORD_ZERO, 1'b0};
            S_A_GRANT:   w = '{C_ALWAYS, S_IDLE, ACT_NONE, 1'b1, KIND_ALLOC,
                               BLK_RD, WORD_ZERO, 1'b1};
            S_A_BAD:     w = '{C_ALWAYS, S_A_TEST, ACT_NONE, 1'b1, KIND_BAD,
                               BLK_RD, WORD_ZERO, 1'b0};
            S_A_NOSP:    w = '{C_ALWAYS, S_IDLE, ACT_CNT_CLEAR, 1'b1, KIND_NOSPACE,
                               BLK_ZERO, WORD_ZERO, 1'b1};
            S_A_FETCH:   w = '{C_ALWAYS, S_IDLE, ACT_FETCH_SET, 1'b1, KIND_FETCH,
                               BLK_RD, WORD_ZERO, 1'b1};
            S_R_CLAMP:   w = '{C_NEVER, S_IDLE, ACT_CLAMP, 1'b0, KIND_ALLOC,
                               BLK_ZERO, WORD_ZERO, 1'b0};
            S_R_RANGE:   w = '{C_BN_BAD, S_R_BAD, ACT_NONE, 1'b0, KIND_ALLOC,
                               BLK_ZERO, WORD_ZERO, 1'b0};
            S_R_EMPTY:   w = '{C_CNT_NZ, S_R_FULL, ACT_NONE, 1'b0, KIND_ALLOC,
                               BLK_ZERO, WORD_ZERO, 1'b0};
            S_R_SEED:    w = '{C_NEVER, S_IDLE, ACT_SEED, 1'b0, KIND_ALLOC,
                               BLK_ZERO, WORD_ZERO, 1'b0};
            S_R_FULL:    w = '{C_CNT_LT_DEPTH, S_R_PUSH, ACT_NONE, 1'b0, KIND_ALLOC,
                               BLK_ZERO, WORD_ZERO, 1'b0};
            S_R_SPCNT:   w = '{C_NEVER, S_IDLE, ACT_SPILL_INIT, 1'b1, KIND_SPILL_CNT,
                               BLK_BN, WORD_COUNT, 1'b0};
            S_R_SPENT:   w = '{C_SPILL_MORE, S_R_SPENT, ACT_SPILL_NEXT, 1'b1,
                               KIND_SPILL_ENT, BLK_BN, WORD_RD, 1'b0};
            S_R_RESTART: w = '{C_NEVER, S_IDLE, ACT_CNT_CLEAR, 1'b0, KIND_ALLOC,
                               BLK_ZERO, WORD_ZERO, 1'b0};
            S_R_PUSH:    w = '{C_ALWAYS, S_IDLE, ACT_PUSH, 1'b1, KIND_RELEASED,
                               BLK_BN, WORD_ZERO, 1'b1};
            S_R_BAD:     w = '{C_ALWAYS, S_IDLE, ACT_NONE, 1'b1, KIND_BAD,
                               BLK_BN, WORD_ZERO, 1'b1};
            S_F_CNT:     w = '{C_RF, S_F_FAIL, ACT_NONE, 1'b0, KIND_ALLOC,
                               BLK_ZERO, WORD_ZERO, 1'b0};
            S_F_LOAD:    w = '{C_ALWAYS, S_IDLE, ACT_LOAD_CNT, 1'b0, KIND_ALLOC,
                               BLK_ZERO, WORD_ZERO, 1'b0};
            S_F_FAIL:    w = '{C_ALWAYS, S_A_NOSP, ACT_FAIL, 1'b0, KIND_ALLOC,
                               BLK_ZERO, WORD_ZERO, 1'b0};
            S_F_ENT:     w = '{C_FILL_NOT_LAST, S_IDLE, ACT_FILL, 1'b0, KIND_ALLOC,
                               BLK_ZERO, WORD_ZERO, 1'b0};
            S_F_DONE:    w = '{C_LOADED_ZERO, S_A_NOSP, ACT_FILL_DONE, 1'b0,
                               KIND_ALLOC, BLK_ZERO, WORD_ZERO, 1'b0};
            S_F_GRANT:   w = '{C_ALWAYS, S_IDLE, ACT_NONE, 1'b1, KIND_ALLOC,
                               BLK_PEND, WORD_ZERO, 1'b1};
            default:     w = '{C_ALWAYS, S_IDLE, ACT_NONE, 1'b0, KIND_ALLOC,
                               BLK_ZERO, WORD_ZERO, 1'b0};
        endcase
        return w;
    endfunction

    // entry point of the program for an accepted transaction
    function automatic step_t dispatch(input logic [1:0] cmd, input logic awaiting);
        step_t s;
        unique case (cmd)
            CMD_ALLOC:    s = awaiting ? S_BUSY : S_A_CLAMP;
            CMD_RELEASE:  s = awaiting ? S_BUSY : S_R_CLAMP;
            CMD_FILL_CNT: s = awaiting ? S_F_CNT : S_IDLE;
            CMD_FILL_ENT: s = awaiting ? S_F_ENT : S_IDLE;
            default:      s = S_IDLE;
        endcase
        return s;
    endfunction

endpackage

@@ rtl/chained_free_block_allocator.sv @@
// chained free-block allocator: microcoded sequencer, free stack memory, stream ports
//
// Keeps a stack of DEPTH free block numbers and hands them out or takes them back.
// Input transactions (s_*): tuser carries the command and the read-failure flag,
// tdata the block to release and the refill word. Results leave on m_* with a
// kind in tuser and tlast on the final result of each input transaction.
// Configuration (data_start, volume_blocks) is to be written through cfg_we/cfg_addr/
// cfg_wdata only while the block is idle; the block itself does not enforce this.
// One input transaction is handled at a time; s_tready is high only while the
// sequencer sits at its idle step. An allocation pops again for each out-of-range
// entry it skips, a release spills the whole stack first when it is full, and an
// allocate or release that arrives while a refill is pending gets a busy answer.
// The free stack memory has one write and one registered read port. Results pass
// through one output register, so the next transaction may be accepted while the
// last result still waits. A stalled receiver holds the sequencer on its next
// result-producing step.
// Reset clears the count, the refill state and the configuration; the stack
// memory holds no reset value and is only read where it has been written.
module chained_free_block_allocator #(
    parameter int DEPTH = 50
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,    // [31:0] block_number, [63:32] fill_word
    input  logic [2:0]  s_tuser,    // [1:0] command, [2] read_failed
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,    // [31:0] block_number_res, [63:32] word_value
    output logic [2:0]  m_tuser,    // [2:0] result_kind
    output logic        m_tlast,
    input  logic        cfg_we,
    input  logic [0:0]  cfg_addr,
    input  logic [31:0] cfg_wdata
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int IW = $clog2(DEPTH + 1);
    localparam logic [7:0]    DEPTH_CNT  = 8'(DEPTH);
    localparam logic [AW-1:0] FILL_LAST  = AW'(DEPTH - 1);
    localparam logic [IW-1:0] SPILL_END  = IW'(DEPTH);

    // sequencer and datapath state
    cfba_pkg::step_t pc_reg, pc_next;
    logic [7:0]    count_reg, count_next;
    logic          awaiting_reg, awaiting_next;
    logic [31:0]   pending_reg, pending_next;
    logic [AW-1:0] fill_idx_reg, fill_idx_next;
    logic [7:0]    loaded_reg, loaded_next;
    logic [IW-1:0] spill_idx_reg, spill_idx_next;
    logic [31:0]   bn_reg, bn_next;
    logic [31:0]   fw_reg, fw_next;
    logic          rf_reg, rf_next;
    logic [31:0]   data_start_reg, volume_blocks_reg;

    // output register
    logic          out_valid_reg;
    logic [2:0]    out_kind_reg;
    logic [31:0]   out_blk_reg, out_word_reg;
    logic          out_last_reg;

    // free stack memory
    logic [31:0]   free_stack [DEPTH];
    logic [31:0]   rd_data_reg;
    logic          mem_we, mem_re;
    logic [AW-1:0] mem_waddr, mem_raddr;
    logic [31:0]   mem_wdata;

    cfba_pkg::uword_t uw;
    logic          out_free, fire, cond_true, rd_bad, bn_bad;
    logic [7:0]    cnt_dec;
    logic [31:0]   emit_blk, emit_word;

    assign out_free = !out_valid_reg || m_tready;
    assign s_tready = (pc_reg == cfba_pkg::S_IDLE);
    assign rd_bad   = (rd_data_reg < data_start_reg) || (rd_data_reg >= volume_blocks_reg);
    assign bn_bad   = (bn_reg < data_start_reg) || (bn_reg >= volume_blocks_reg);
    assign cnt_dec  = count_reg - 8'd1;

    // control word fetch and branch condition
    always_comb
    begin
        uw = cfba_pkg::ucode_rom(pc_reg);
        unique case (uw.cond)
            cfba_pkg::C_NEVER:         cond_true = 1'b0;
            cfba_pkg::C_ALWAYS:        cond_true = 1'b1;
            cfba_pkg::C_CNT_ZERO:      cond_true = (count_reg == 8'd0);
            cfba_pkg::C_CNT_NZ:        cond_true = (count_reg != 8'd0);
            cfba_pkg::C_CNT_LT_DEPTH:  cond_true = (count_reg < DEPTH_CNT);
            cfba_pkg::C_RD_ZERO:       cond_true = (rd_data_reg == 32'd0);
            cfba_pkg::C_RD_BAD:        cond_true = rd_bad;
            cfba_pkg::C_BN_BAD:        cond_true = bn_bad;
            cfba_pkg::C_RF:            cond_true = rf_reg;
            cfba_pkg::C_FILL_NOT_LAST: cond_true = (fill_idx_reg != FILL_LAST);
            cfba_pkg::C_LOADED_ZERO:   cond_true = (loaded_reg == 8'd0);
            cfba_pkg::C_SPILL_MORE:    cond_true = (spill_idx_reg != SPILL_END);
            default:                   cond_true = 1'b0;
        endcase
        if (uw.act == cfba_pkg::ACT_WAIT_IN)
            fire = s_tvalid;
        else
            fire = !uw.emit || out_free;
    end

    // result payload selection
    always_comb
    begin
        unique case (uw.blk_sel)
            cfba_pkg::BLK_RD:   emit_blk = rd_data_reg;
            cfba_pkg::BLK_BN:   emit_blk = bn_reg;
            cfba_pkg::BLK_PEND: emit_blk = pending_reg;
            default:            emit_blk = 32'd0;
        endcase
        unique case (uw.word_sel)
            cfba_pkg::WORD_COUNT: emit_word = {24'd0, count_reg};
            cfba_pkg::WORD_RD:    emit_word = rd_data_reg;
            default:              emit_word = 32'd0;
        endcase
    end

    // datapath operations and next step
    always_comb
    begin
        pc_next        = pc_reg;
        count_next     = count_reg;
        awaiting_next  = awaiting_reg;
        pending_next   = pending_reg;
        fill_idx_next  = fill_idx_reg;
        loaded_next    = loaded_reg;
        spill_idx_next = spill_idx_reg;
        bn_next        = bn_reg;
        fw_next        = fw_reg;
        rf_next        = rf_reg;
        mem_we         = 1'b0;
        mem_waddr      = '0;
        mem_wdata      = 32'd0;
        mem_re         = 1'b0;
        mem_raddr      = '0;
        if (fire)
        begin
            unique case (uw.act)
                cfba_pkg::ACT_WAIT_IN:
                begin
                    bn_next = s_tdata[31:0];
                    fw_next = s_tdata[63:32];
                    rf_next = s_tuser[2];
                end
                cfba_pkg::ACT_CLAMP:
                begin
                    if (count_reg > DEPTH_CNT)
                        count_next = 8'd0;
                end
                cfba_pkg::ACT_POP:
                begin
                    count_next = cnt_dec;
                    mem_re     = 1'b1;
                    mem_raddr  = cnt_dec[AW-1:0];
                end
                cfba_pkg::ACT_CNT_CLEAR:
                begin
                    count_next = 8'd0;
                end
                cfba_pkg::ACT_FETCH_SET:
                begin
                    awaiting_next = 1'b1;
                    pending_next  = rd_data_reg;
                    fill_idx_next = '0;
                    loaded_next   = 8'd0;
                end
                cfba_pkg::ACT_SEED:
                begin
                    mem_we     = 1'b1;
                    mem_waddr  = '0;
                    mem_wdata  = 32'd0;
                    count_next = 8'd1;
                end
                cfba_pkg::ACT_SPILL_INIT:
                begin
                    mem_re         = 1'b1;
                    mem_raddr      = '0;
                    spill_idx_next = IW'(1);
                end
                cfba_pkg::ACT_SPILL_NEXT:
                begin
                    mem_re         = (spill_idx_reg < SPILL_END);
                    mem_raddr      = spill_idx_reg[AW-1:0];
                    spill_idx_next = spill_idx_reg + IW'(1);
                end
                cfba_pkg::ACT_PUSH:
                begin
                    mem_we     = 1'b1;
                    mem_waddr  = count_reg[AW-1:0];
                    mem_wdata  = bn_reg;
                    count_next = count_reg + 8'd1;
                end
                cfba_pkg::ACT_LOAD_CNT:
                begin
                    loaded_next = (|fw_reg[31:8]) ? 8'hFF : fw_reg[7:0];
                end
                cfba_pkg::ACT_FAIL:
                begin
                    awaiting_next = 1'b0;
                    fill_idx_next = '0;
                    count_next    = 8'd0;
                end
                cfba_pkg::ACT_FILL:
                begin
                    mem_we        = 1'b1;
                    mem_waddr     = fill_idx_reg;
                    mem_wdata     = fw_reg;
                    fill_idx_next = fill_idx_reg + AW'(1);
                end
                cfba_pkg::ACT_FILL_DONE:
                begin
                    awaiting_next = 1'b0;
                    fill_idx_next = '0;
                    count_next    = loaded_reg;
                end
                default:
                begin
                end
            endcase
            if (uw.act == cfba_pkg::ACT_WAIT_IN)
                pc_next = cfba_pkg::dispatch(s_tuser[1:0], awaiting_reg);
            else if (cond_true)
                pc_next = uw.target;
            else
                pc_next = pc_reg + 5'd1;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg        <= cfba_pkg::S_IDLE;
            count_reg     <= 8'd0;
            awaiting_reg  <= 1'b0;
            pending_reg   <= 32'd0;
            fill_idx_reg  <= '0;
            loaded_reg    <= 8'd0;
            spill_idx_reg <= '0;
        end
        else
        begin
            pc_reg        <= pc_next;
            count_reg     <= count_next;
            awaiting_reg  <= awaiting_next;
            pending_reg   <= pending_next;
            fill_idx_reg  <= fill_idx_next;
            loaded_reg    <= loaded_next;
            spill_idx_reg <= spill_idx_next;
        end
    end

    // latched input transaction
    always_ff @(posedge clk)
    begin
        bn_reg <= bn_next;
        fw_reg <= fw_next;
        rf_reg <= rf_next;
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            data_start_reg    <= 32'd0;
            volume_blocks_reg <= 32'd0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                cfba_pkg::REG_DATA_START:    data_start_reg    <= cfg_wdata;
                cfba_pkg::REG_VOLUME_BLOCKS: volume_blocks_reg <= cfg_wdata;
                default:
                begin
                end
            endcase
        end
    end

    // free stack memory, registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
            free_stack[mem_waddr] <= mem_wdata;
        if (mem_re)
            rd_data_reg <= free_stack[mem_raddr];
    end

    // output register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (fire && uw.emit)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    // output register payload
    always_ff @(posedge clk)
    begin
        if (fire && uw.emit)
        begin
            out_kind_reg <= uw.kind;
            out_blk_reg  <= emit_blk;
            out_word_reg <= emit_word;
            out_last_reg <= uw.last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_word_reg, out_blk_reg};
    assign m_tuser  = out_kind_reg;
    assign m_tlast  = out_last_reg;

    // allocation never runs while a refill is pending
    a_pop_not_awaiting: assert property (@(posedge clk) disable iff (!rst_n)
        (pc_reg == cfba_pkg::S_A_POP) |-> !awaiting_reg)
        else $error("pop step reached while a refill is pending");

    // the count is clamped before the pop loop starts
    a_test_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (pc_reg == cfba_pkg::S_A_TEST) |-> (count_reg <= DEPTH_CNT))
        else $error("pop loop entered with count above depth");

    // a push always lands inside the stack
    a_push_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (pc_reg == cfba_pkg::S_R_PUSH) |-> (count_reg < DEPTH_CNT))
        else $error("push with a full stack");

    // spill index stays within one past the last entry
    a_spill_index: assert property (@(posedge clk) disable iff (!rst_n)
        (pc_reg == cfba_pkg::S_R_SPENT) |->
            (spill_idx_reg != IW'(0)) && (spill_idx_reg <= SPILL_END))
        else $error("spill index out of range");

    // the refill index never runs past the last entry until the refill closes
    a_fill_index: assert property (@(posedge clk) disable iff (!rst_n)
        (awaiting_reg && (pc_reg != cfba_pkg::S_F_DONE)) |-> (fill_idx_reg <= FILL_LAST))
        else $error("refill index past the last entry");

endmodule

@@ dv/tb_top.sv @@
// self-checking testbench for the chained free-block allocator
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          DEPTH       = 50;
    localparam int unsigned CYCLE_LIMIT = 1_000_000;

    // one result of the allocator as seen on the master side
    typedef struct packed {
        logic [2:0]  kind;
        logic [31:0] blk;
        logic [31:0] word;
        logic        last;
    } alloc_reply_t;

    // ways a chain-block refill can go
    typedef enum logic [2:0] {
        FILL_FAIL,
        FILL_PARTIAL,
        FILL_FULL,
        FILL_OVERSIZE,
        FILL_EMPTY
    } fill_plan_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [63:0] s_tdata;     // [31:0] block_number, [63:32] fill_word
    logic [2:0]  s_tuser;     // [1:0] command, [2] read_failed
    logic        m_tvalid;
    logic        m_tready;
    logic [63:0] m_tdata;     // [31:0] block_number_res, [63:32] word_value
    logic [2:0]  m_tuser;     // [2:0] result_kind
    logic        m_tlast;
    logic        cfg_we;
    logic [0:0]  cfg_addr;
    logic [31:0] cfg_wdata;

    // shadow copy of the allocator state and its configuration
    logic [31:0]  shadow_stack [DEPTH];
    int unsigned  shadow_count;
    logic         shadow_refill;
    logic [31:0]  shadow_pending;
    int unsigned  shadow_fill_idx;
    int unsigned  shadow_loaded;
    logic [31:0]  cfg_first;
    logic [31:0]  cfg_total;
    logic [2:0]   last_kind;

    alloc_reply_t alloc_replies [$];
    int unsigned  live_items;
    int unsigned  mismatches;
    int unsigned  cycle_count;
    bit           gaps_on;

    chained_free_block_allocator #(.DEPTH(DEPTH)) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // run limit
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("tb_top: errors");
        $finish;
    end

    function automatic alloc_reply_t reply(input logic [2:0] kind, input logic [31:0] blk,
                                           input logic [31:0] word);
        alloc_reply_t r;
        r.kind = kind;
        r.blk  = blk;
        r.word = word;
        r.last = 1'b0;
        return r;
    endfunction

    function automatic logic outside_volume(input logic [31:0] bn);
        return (bn < cfg_first) || (bn >= cfg_total);
    endfunction

    function automatic logic volume_empty();
        return cfg_total <= cfg_first;
    endfunction

    function automatic logic [31:0] in_range_block();
        return cfg_first + $urandom_range(0, cfg_total - cfg_first - 1);
    endfunction

    // mostly valid blocks, some arbitrary values, now and then a zero
    function automatic logic [31:0] pick_block();
        int unsigned roll;
        roll = $urandom_range(0, 19);
        if (roll == 0)
            return 32'd0;
        if (roll <= 3 || volume_empty())
            return $urandom;
        return in_range_block();
    endfunction

    // allocator behavior for one accepted transaction
    task automatic allocator_step(input logic [1:0] cmd, input logic [31:0] blk,
                                  input logic [31:0] word, input logic rf);
        alloc_reply_t batch [$];
        logic [31:0]  popped;
        logic         granted;
        logic         hit_zero;
        popped   = '0;
        granted  = 1'b0;
        hit_zero = 1'b0;
        if (cmd == cfba_pkg::CMD_ALLOC || cmd == cfba_pkg::CMD_RELEASE)
        begin
            if (shadow_refill)
                batch.push_back(reply(cfba_pkg::KIND_BUSY, 32'd0, 32'd0));
            else
            begin
                if (shadow_count > DEPTH)
                    shadow_count = 0;
                if (cmd == cfba_pkg::CMD_ALLOC)
                begin
                    // pop until a usable block, the chain terminator or an empty stack
                    while (shadow_count != 0 && !granted && !hit_zero)
                    begin
                        shadow_count--;
                        popped = shadow_stack[shadow_count];
                        if (popped == 32'd0)
                            hit_zero = 1'b1;
                        else if (outside_volume(popped))
                            batch.push_back(reply(cfba_pkg::KIND_BAD, popped, 32'd0));
                        else
                            granted = 1'b1;
                    end
                    if (!granted)
                    begin
                        shadow_count = 0;
                        batch.push_back(reply(cfba_pkg::KIND_NOSPACE, 32'd0, 32'd0));
                    end
                    else if (shadow_count == 0)
                    begin
                        // last entry is the next chain link
                        shadow_refill   = 1'b1;
                        shadow_pending  = popped;
                        shadow_fill_idx = 0;
                        shadow_loaded   = 0;
                        batch.push_back(reply(cfba_pkg::KIND_FETCH, popped, 32'd0));
                    end
                    else
                        batch.push_back(reply(cfba_pkg::KIND_ALLOC, popped, 32'd0));
                end
                else if (outside_volume(blk))
                    batch.push_back(reply(cfba_pkg::KIND_BAD, blk, 32'd0));
                else
                begin
                    if (shadow_count == 0)
                    begin
                        shadow_count    = 1;
                        shadow_stack[0] = 32'd0;
                    end
                    // full stack moves into the released block
                    if (shadow_count >= DEPTH)
                    begin
                        batch.push_back(reply(cfba_pkg::KIND_SPILL_CNT, blk, shadow_count));
                        for (int i = 0; i < DEPTH; i++)
                            batch.push_back(reply(cfba_pkg::KIND_SPILL_ENT, blk,
                                                  shadow_stack[i]));
                        shadow_count = 0;
                    end
                    shadow_stack[shadow_count] = blk;
                    shadow_count++;
                    batch.push_back(reply(cfba_pkg::KIND_RELEASED, blk, 32'd0));
                end
            end
        end
        else if (shadow_refill)
        begin
            if (cmd == cfba_pkg::CMD_FILL_CNT)
            begin
                if (rf)
                begin
                    shadow_refill   = 1'b0;
                    shadow_fill_idx = 0;
                    shadow_count    = 0;
                    batch.push_back(reply(cfba_pkg::KIND_NOSPACE, 32'd0, 32'd0));
                end
                else
                    shadow_loaded = (word > 32'd255) ? 255 : word;
            end
            else
            begin
                shadow_stack[shadow_fill_idx] = word;
                shadow_fill_idx++;
                if (shadow_fill_idx >= DEPTH)
                begin
                    shadow_refill   = 1'b0;
                    shadow_fill_idx = 0;
                    shadow_count    = shadow_loaded;
                    if (shadow_count == 0)
                        batch.push_back(reply(cfba_pkg::KIND_NOSPACE, 32'd0, 32'd0));
                    else
                        batch.push_back(reply(cfba_pkg::KIND_ALLOC, shadow_pending, 32'd0));
                end
            end
        end
        if (batch.size() != 0)
        begin
            batch[batch.size() - 1].last = 1'b1;
            last_kind = batch[batch.size() - 1].kind;
        end
        foreach (batch[i])
            alloc_replies.push_back(batch[i]);
    endtask

    // one input transaction, with an occasional idle burst ahead of it
    task automatic send_item(input logic [1:0] cmd, input logic [31:0] blk,
                             input logic [31:0] word, input logic rf);
        if (gaps_on && $urandom_range(0, 3) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {word, blk};
        s_tuser  <= {rf, cmd};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        if (cmd == cfba_pkg::CMD_ALLOC || cmd == cfba_pkg::CMD_RELEASE || shadow_refill)
            live_items++;
        allocator_step(cmd, blk, word, rf);
    endtask

    task automatic do_alloc();
        send_item(cfba_pkg::CMD_ALLOC, $urandom, $urandom, 1'($urandom_range(0, 1)));
    endtask

    task automatic do_release(input logic [31:0] bn);
        send_item(cfba_pkg::CMD_RELEASE, bn, $urandom, 1'($urandom_range(0, 1)));
    endtask

    // hold off until every result is back and the sequencer has settled
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (alloc_replies.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    task automatic load_config(input logic [31:0] first, input logic [31:0] total);
        wait_idle();
        cfg_we    <= 1'b1;
        cfg_addr  <= cfba_pkg::REG_DATA_START;
        cfg_wdata <= first;
        @(posedge clk);
        cfg_addr  <= cfba_pkg::REG_VOLUME_BLOCKS;
        cfg_wdata <= total;
        @(posedge clk);
        cfg_we    <= 1'b0;
        cfg_first = first;
        cfg_total = total;
    endtask

    // release valid blocks until the stack is exactly full
    task automatic grow_stack();
        if (!volume_empty() && !shadow_refill)
            while (shadow_count != DEPTH)
                do_release(in_range_block());
    endtask

    // allocate until a fetch is raised, the free list runs dry or DEPTH + 1 allocations are sent
    task automatic alloc_run();
        int unsigned n;
        n = 0;
        do
        begin
            do_alloc();
            n++;
        end
        while (!shadow_refill && last_kind != cfba_pkg::KIND_NOSPACE && n <= DEPTH);
    endtask

    // answer a pending fetch with a count and a block of entries
    task automatic refill_chain(input fill_plan_t plan);
        logic [31:0] tally;
        int unsigned poke_at;
        case (plan)
            FILL_PARTIAL:  tally = $urandom_range(1, DEPTH - 1);
            FILL_FULL:     tally = DEPTH;
            FILL_OVERSIZE: tally = $urandom_range(0, 1) ? 32'hFFFF_FFFF
                                                        : $urandom_range(DEPTH + 1, 300);
            FILL_EMPTY:    tally = 32'd0;
            default:       tally = $urandom;
        endcase
        if (plan == FILL_FAIL)
            send_item(cfba_pkg::CMD_FILL_CNT, $urandom, tally, 1'b1);
        else
        begin
            // sometimes a stale count that the real one overwrites
            if ($urandom_range(0, 3) == 0)
                send_item(cfba_pkg::CMD_FILL_CNT, $urandom, $urandom, 1'b0);
            send_item(cfba_pkg::CMD_FILL_CNT, $urandom, tally, 1'b0);
            poke_at = $urandom_range(0, 3 * DEPTH);
            for (int i = 0; i < DEPTH; i++)
            begin
                if (i == poke_at)
                    send_item(1'($urandom_range(0, 1)) ? cfba_pkg::CMD_RELEASE
                                                       : cfba_pkg::CMD_ALLOC,
                              $urandom, $urandom, 1'($urandom_range(0, 1)));
                send_item(cfba_pkg::CMD_FILL_ENT, $urandom, pick_block(),
                          1'($urandom_range(0, 1)));
            end
        end
    endtask

    // a burst of arbitrary transactions
    task automatic mixed_burst();
        repeat ($urandom_range(1, 8))
        begin
            case ($urandom_range(0, 5))
                0, 1:    do_alloc();
                2, 3:    do_release(pick_block());
                4:       send_item(cfba_pkg::CMD_FILL_CNT, $urandom, $urandom,
                                   1'($urandom_range(0, 1)));
                default: send_item(cfba_pkg::CMD_FILL_ENT, $urandom, $urandom,
                                   1'($urandom_range(0, 1)));
            endcase
        end
    endtask

    // one piece of random traffic steered by the shadow state
    task automatic random_episode();
        if (shadow_refill)
            refill_chain(fill_plan_t'($urandom_range(0, 4)));
        else if (shadow_count == DEPTH && !volume_empty())
            do_release(in_range_block());
        else
            case ($urandom_range(0, 5))
                0:       grow_stack();
                1, 2:    alloc_run();
                default: mixed_burst();
            endcase
    endtask

    task automatic random_phase(input int unsigned budget);
        int unsigned start;
        start = live_items;
        while (live_items - start < budget)
            random_episode();
    endtask

    // reset values, field extremes, range edges, bad skips and the terminator
    task automatic test_directed();
        do_alloc();
        do_release(32'hFFFF_FFFF);
        send_item(cfba_pkg::CMD_FILL_CNT, 32'd0, 32'hFFFF_FFFF, 1'b1);
        send_item(cfba_pkg::CMD_FILL_ENT, 32'hFFFF_FFFF, 32'd0, 1'b0);
        load_config(32'd0, 32'hFFFF_FFFF);
        do_release(32'd0);
        do_release(32'hFFFF_FFFE);
        do_release(32'hFFFF_FFFF);
        do_alloc();
        do_alloc();
        load_config(32'd100, 32'd200);
        do_release(32'd150);
        do_release(32'd99);
        do_release(32'd100);
        do_release(32'd199);
        do_release(32'd200);
        load_config(32'd150, 32'd200);
        do_alloc();
        do_alloc();
        do_alloc();
    endtask

    // spill, fetch, busy answers, a full refill, then a failed read
    task automatic test_chain();
        load_config(32'd16, 32'h0010_0000);
        grow_stack();
        do_release(in_range_block());
        do_alloc();
        do_alloc();
        do_release(in_range_block());
        refill_chain(FILL_FULL);
        do_release(in_range_block());
        do_alloc();
        do_release(in_range_block());
        refill_chain(FILL_FAIL);
    endtask

    // random traffic over several volume layouts
    task automatic test_random_volumes();
        logic [31:0] first;
        load_config(32'd0, 32'hFFFF_FFFF);
        random_phase(10);
        first = $urandom_range(1, 4096);
        load_config(first, first + $urandom_range(200, 1_000_000));
        random_phase(10);
        load_config(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        random_phase(4);
        load_config($urandom_range(0, 31), 32'h0000_8000);
        random_phase(6);
    endtask

    // closing stretch at full rate on both sides
    task automatic test_full_rate();
        load_config(32'd16, 32'h0010_0000);
        gaps_on = 1'b0;
        random_phase(12);
    endtask

    // receiver with random stall bursts
    initial
    begin
        m_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (gaps_on && $urandom_range(0, 5) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 13)) @(posedge clk);
            end
            m_tready <= 1'b1;
        end
    end

    // compare each result transaction with the oldest prediction
    always @(posedge clk)
    begin : result_check
        alloc_reply_t want;
        alloc_reply_t got;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.kind = m_tuser;
            got.blk  = m_tdata[31:0];
            got.word = m_tdata[63:32];
            got.last = m_tlast;
            if (alloc_replies.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: kind %0d blk %h word %h last %b",
                             got.kind, got.blk, got.word, got.last);
            end
            else
            begin
                want = alloc_replies.pop_front();
                if (want.kind != got.kind || want.blk != got.blk ||
                    want.word != got.word || want.last != got.last)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"result mismatch: expected kind %0d blk %h word %h last %b,",
                                  " got kind %0d blk %h word %h last %b"},
                                 want.kind, want.blk, want.word, want.last,
                                 got.kind, got.blk, got.word, got.last);
                end
            end
        end
    end

    // reset, tests in turn, final verdict
    initial
    begin
        rst_n     <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= '0;
        cfg_we    <= 1'b0;
        cfg_addr  <= '0;
        cfg_wdata <= '0;
        gaps_on         = 1'b1;
        live_items      = 0;
        mismatches      = 0;
        shadow_count    = 0;
        shadow_refill   = 1'b0;
        shadow_pending  = '0;
        shadow_fill_idx = 0;
        shadow_loaded   = 0;
        cfg_first       = '0;
        cfg_total       = '0;
        last_kind       = cfba_pkg::KIND_ALLOC;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_chain();
        test_random_volumes();
        test_full_rate();

        wait_idle();
        if (mismatches == 0 && alloc_replies.size() == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

endmodule
